/* sv/fxc_pkg.sv */
package fxc_pkg;

	localparam int unsigned MIN_FRAME_BYTES = 6;
	localparam int unsigned PAYLOAD_START   = 5;

	typedef enum logic [2:0] {
		CFG_START_BYTE    = 3'd0,
		CFG_END_BYTE      = 3'd1,
		CFG_TYPE_COMMAND  = 3'd2,
		CFG_TYPE_RESPONSE = 3'd3,
		CFG_TYPE_STATUS   = 3'd4,
		CFG_TYPE_ERROR    = 3'd5
	} cfg_index_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_MALFORMED = 3'd1,
		ST_LENGTH    = 3'd2,
		ST_CHECKSUM  = 3'd3,
		ST_TYPE      = 3'd4
	} status_t;

	typedef enum logic {
		KIND_PAYLOAD = 1'b0,
		KIND_STATUS  = 1'b1
	} kind_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_last;
	} rx_item_t;

	typedef struct packed {
		logic       item_kind;
		logic [7:0] payload_byte;
		logic [7:0] payload_index;
		logic [2:0] frame_status;
		logic [7:0] recipient;
		logic [7:0] frame_type;
		logic [7:0] frame_len;
	} res_item_t;

	typedef struct packed {
		logic [7:0] start_byte;
		logic [7:0] end_byte;
		logic [7:0] type_command;
		logic [7:0] type_response;
		logic [7:0] type_status;
		logic [7:0] type_error;
	} cfg_t;

	typedef struct packed {
		logic [7:0] last_byte;
		logic       start_matched;
		logic [7:0] xor_sum;
		logic [7:0] held_type;
		logic [7:0] held_length;
	} frame_info_t;

endpackage

/* sv/frame_receiver_xor_checksum.sv */
// latency: a byte accepted into the input register reaches the result register when the frame state advances
// throughput: one byte per cycle while the result output is not stalled, set by the single-stage frame state update
// bytes that produce no result (header bytes) still pass through the input register and advance the frame state
// reset: asynchronous, active low; clears frame state and handshake valids
// and loads the default delimiter and type registers
module frame_receiver_xor_checksum
	import fxc_pkg::*;
#(
	parameter int unsigned POSITION_LIMIT = 511
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_wdata,
	input  logic       rx_valid,
	output logic       rx_ready,
	input  rx_item_t   rx_data,
	output logic       res_valid,
	input  logic       res_ready,
	output res_item_t  res_data
);

	localparam int unsigned PW = $clog2(POSITION_LIMIT + 1);

	cfg_t        cfg_q;
	logic        valid_s1;
	rx_item_t    item_s1;
	logic        res_valid_q;
	res_item_t   res_q;
	logic [PW-1:0] pos_q;
	logic [7:0]  xor_q;
	logic        start_q;
	logic [7:0]  recip_q;
	logic [7:0]  type_q;
	logic [7:0]  len_q;
	logic        advance;
	frame_info_t info;
	status_t     status;
	logic [PW-1:0] idx_full;
	logic [7:0]  idx_sat;
	logic        has_payload;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte    <= 8'd170;
			cfg_q.end_byte      <= 8'd85;
			cfg_q.type_command  <= 8'd1;
			cfg_q.type_response <= 8'd2;
			cfg_q.type_status   <= 8'd3;
			cfg_q.type_error    <= 8'd4;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_START_BYTE:    cfg_q.start_byte    <= cfg_wdata;
				CFG_END_BYTE:      cfg_q.end_byte      <= cfg_wdata;
				CFG_TYPE_COMMAND:  cfg_q.type_command  <= cfg_wdata;
				CFG_TYPE_RESPONSE: cfg_q.type_response <= cfg_wdata;
				CFG_TYPE_STATUS:   cfg_q.type_status   <= cfg_wdata;
				CFG_TYPE_ERROR:    cfg_q.type_error    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign advance  = valid_s1 && (!res_valid_q || res_ready);
	assign rx_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_ready && rx_valid) begin
			item_s1 <= rx_data;
		end
	end

	assign info.last_byte     = item_s1.rx_byte;
	assign info.start_matched = start_q;
	assign info.xor_sum       = xor_q;
	assign info.held_type     = type_q;
	assign info.held_length   = len_q;

	fxc_check #(
		.PW(PW)
	) u_check (
		.byte_pos (pos_q),
		.info     (info),
		.cfg      (cfg_q),
		.status   (status)
	);

	assign has_payload = pos_q >= PW'(PAYLOAD_START);
	assign idx_full    = pos_q - PW'(PAYLOAD_START);
	assign idx_sat     = (|idx_full[PW-1:8]) ? 8'hff : idx_full[7:0];

	// frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			xor_q   <= '0;
			start_q <= 1'b0;
			recip_q <= '0;
			type_q  <= '0;
			len_q   <= '0;
		end else if (advance) begin
			if (item_s1.frame_last) begin
				pos_q   <= '0;
				xor_q   <= '0;
				start_q <= 1'b0;
				recip_q <= '0;
				type_q  <= '0;
				len_q   <= '0;
			end else begin
				if (pos_q == '0) begin
					start_q <= (item_s1.rx_byte == cfg_q.start_byte);
				end else begin
					xor_q <= xor_q ^ item_s1.rx_byte;
					if (pos_q == PW'(1)) begin
						recip_q <= item_s1.rx_byte;
					end
					if (pos_q == PW'(2)) begin
						type_q <= item_s1.rx_byte;
					end
					if (pos_q == PW'(3)) begin
						len_q <= item_s1.rx_byte;
					end
				end
				if (pos_q < PW'(POSITION_LIMIT)) begin
					pos_q <= pos_q + PW'(1);
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= item_s1.frame_last || has_payload;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.recipient  <= recip_q;
			res_q.frame_type <= type_q;
			res_q.frame_len  <= len_q;
			if (item_s1.frame_last) begin
				res_q.item_kind     <= KIND_STATUS;
				res_q.payload_byte  <= 8'd0;
				res_q.payload_index <= 8'd0;
				res_q.frame_status  <= status;
			end else begin
				res_q.item_kind     <= KIND_PAYLOAD;
				res_q.payload_byte  <= item_s1.rx_byte;
				res_q.payload_index <= idx_sat;
				res_q.frame_status  <= ST_OK;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

`ifndef SYNTHESIS
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.frame_last |=> pos_q == '0 && xor_q == '0 && !start_q)
		else $error("frame state not cleared after last byte");

	a_pos_count: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !item_s1.frame_last && pos_q < PW'(POSITION_LIMIT)
		|=> pos_q == $past(pos_q) + PW'(1))
		else $error("byte position did not advance");

	a_status_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.item_kind == KIND_STATUS
		|-> res_q.payload_byte == 8'd0 && res_q.payload_index == 8'd0)
		else $error("status transfer carries payload data");

	a_payload_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.item_kind == KIND_PAYLOAD |-> res_q.frame_status == ST_OK)
		else $error("payload transfer carries a status");
`endif

endmodule

/* sv/fxc_check.sv */
module fxc_check
	import fxc_pkg::*;
#(
	parameter int unsigned PW = 9
) (
	input  logic [PW-1:0] byte_pos,
	input  frame_info_t   info,
	input  cfg_t          cfg,
	output status_t       status
);

	logic [PW:0] total;
	logic [PW:0] expected;
	logic        type_known;

	assign total    = {1'b0, byte_pos} + (PW+1)'(1);
	assign expected = (PW+1)'(MIN_FRAME_BYTES) + (PW+1)'(info.held_length);

	assign type_known = (info.held_type == cfg.type_command)
		|| (info.held_type == cfg.type_response)
		|| (info.held_type == cfg.type_status)
		|| (info.held_type == cfg.type_error);

	always_comb begin
		if (total < (PW+1)'(MIN_FRAME_BYTES) || !info.start_matched
			|| info.last_byte != cfg.end_byte) begin
			status = ST_MALFORMED;
		end else if (total != expected) begin
			status = ST_LENGTH;
		end else if (info.xor_sum != 8'd0) begin
			status = ST_CHECKSUM;
		end else if (!type_known) begin
			status = ST_TYPE;
		end else begin
			status = ST_OK;
		end
	end

endmodule

/* tb/frame_checker.sv */
module frame_checker
	import fxc_pkg::*;
#(
	parameter int unsigned POSITION_LIMIT = 511
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_wdata,
	input  logic       rx_valid,
	input  logic       rx_ready,
	input  rx_item_t   rx_data,
	input  logic       res_valid,
	input  logic       res_ready,
	input  res_item_t  res_data,
	output int         mismatches,
	output int         outstanding
);

	cfg_t        regs;
	int unsigned byte_count;
	logic [7:0]  running_xor;
	logic        start_seen;
	logic [7:0]  held_rcp;
	logic [7:0]  held_typ;
	logic [7:0]  held_len;
	res_item_t   expected_items[$];
	int          fail_total;

	task automatic clear_frame();
		byte_count = 0;
		running_xor = '0;
		start_seen = 1'b0;
		held_rcp = '0;
		held_typ = '0;
		held_len = '0;
	endtask

	function automatic status_t frame_status_of(input logic [7:0] last_byte);
		int unsigned total;
		total = byte_count + 1;
		if (total < MIN_FRAME_BYTES || !start_seen || last_byte != regs.end_byte)
			return ST_MALFORMED;
		if (total != MIN_FRAME_BYTES + held_len)
			return ST_LENGTH;
		if (running_xor != 8'h00)
			return ST_CHECKSUM;
		if (held_typ != regs.type_command && held_typ != regs.type_response &&
		    held_typ != regs.type_status && held_typ != regs.type_error)
			return ST_TYPE;
		return ST_OK;
	endfunction

	task automatic predict_byte(input rx_item_t it);
		res_item_t   r;
		int unsigned idx;
		r = '0;
		if (it.frame_last) begin
			r.item_kind = KIND_STATUS;
			r.frame_status = frame_status_of(it.rx_byte);
			r.recipient = held_rcp;
			r.frame_type = held_typ;
			r.frame_len = held_len;
			expected_items.push_back(r);
			clear_frame();
		end else begin
			if (byte_count == 0) begin
				start_seen = (it.rx_byte == regs.start_byte);
			end else begin
				running_xor ^= it.rx_byte;
				if (byte_count == 1)
					held_rcp = it.rx_byte;
				else if (byte_count == 2)
					held_typ = it.rx_byte;
				else if (byte_count == 3)
					held_len = it.rx_byte;
			end
			if (byte_count >= PAYLOAD_START) begin
				idx = byte_count - PAYLOAD_START;
				r.item_kind = KIND_PAYLOAD;
				r.payload_byte = it.rx_byte;
				r.payload_index = (idx > 255) ? 8'd255 : idx[7:0];
				r.frame_status = ST_OK;
				r.recipient = held_rcp;
				r.frame_type = held_typ;
				r.frame_len = held_len;
				expected_items.push_back(r);
			end
			if (byte_count < POSITION_LIMIT)
				byte_count++;
		end
	endtask

	task automatic check_result(input res_item_t got);
		res_item_t e;
		if (expected_items.size() == 0) begin
			if (fail_total < 10)
				$display("unexpected result: kind=%0d byte=%02h idx=%0d status=%0d",
					got.item_kind, got.payload_byte, got.payload_index, got.frame_status);
			fail_total++;
		end else begin
			e = expected_items.pop_front();
			if (e.item_kind !== got.item_kind || e.payload_byte !== got.payload_byte ||
			    e.payload_index !== got.payload_index ||
			    e.frame_status !== got.frame_status || e.recipient !== got.recipient ||
			    e.frame_type !== got.frame_type ||
			    e.frame_len !== got.frame_len) begin
				if (fail_total < 10) begin
					$display("exp: kind=%0d byte=%02h idx=%0d st=%0d rcp=%02h typ=%02h len=%02h",
						e.item_kind, e.payload_byte, e.payload_index, e.frame_status,
						e.recipient, e.frame_type, e.frame_len);
					$display("got: kind=%0d byte=%02h idx=%0d st=%0d rcp=%02h typ=%02h len=%02h",
						got.item_kind, got.payload_byte, got.payload_index, got.frame_status,
						got.recipient, got.frame_type, got.frame_len);
				end
				fail_total++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs <= '{start_byte: 8'd170, end_byte: 8'd85, type_command: 8'd1,
				type_response: 8'd2, type_status: 8'd3, type_error: 8'd4};
			clear_frame();
			expected_items.delete();
			fail_total = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			// results leave before this edge's byte can add a new expectation
			if (res_valid && res_ready)
				check_result(res_data);
			if (rx_valid && rx_ready)
				predict_byte(rx_data);
			if (cfg_we) begin
				case (cfg_index)
					CFG_START_BYTE:    regs.start_byte    <= cfg_wdata;
					CFG_END_BYTE:      regs.end_byte      <= cfg_wdata;
					CFG_TYPE_COMMAND:  regs.type_command  <= cfg_wdata;
					CFG_TYPE_RESPONSE: regs.type_response <= cfg_wdata;
					CFG_TYPE_STATUS:   regs.type_status   <= cfg_wdata;
					CFG_TYPE_ERROR:    regs.type_error    <= cfg_wdata;
					default: ;
				endcase
			end
			mismatches <= fail_total;
			outstanding <= expected_items.size();
		end
	end

endmodule

/* tb/tb_top.sv */
module tb_top;
	import fxc_pkg::*;

	localparam int unsigned POS_LIMIT = 261;
	localparam int QUIET_LIMIT = 4000;
	localparam int PHASE_BYTES = 60;

	typedef enum int {
		FLAW_NONE,
		FLAW_START,
		FLAW_END,
		FLAW_LENGTH,
		FLAW_CHECKSUM,
		FLAW_TYPE,
		FLAW_SHORT,
		FLAW_NOISE
	} flaw_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [2:0] cfg_index = CFG_START_BYTE;
	logic [7:0] cfg_wdata = '0;
	logic       rx_valid = 1'b0;
	logic       rx_ready;
	rx_item_t   rx_data = '0;
	logic       res_valid;
	logic       res_ready = 1'b0;
	res_item_t  res_data;
	int         mismatches;
	int         outstanding;

	cfg_t       live_cfg = '{start_byte: 8'd170, end_byte: 8'd85, type_command: 8'd1,
		type_response: 8'd2, type_status: 8'd3, type_error: 8'd4};
	logic [7:0] frame_buf[$];
	int         burst_left = 0;
	bit         sender_idles = 1'b1;
	int         sent_bytes = 0;
	int         quiet = 0;
	logic [7:0] ready_tick = '0;
	logic [1:0] ready_mode = '0;

	frame_receiver_xor_checksum #(
		.POSITION_LIMIT(POS_LIMIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.rx_valid(rx_valid),
		.rx_ready(rx_ready),
		.rx_data(rx_data),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_data(res_data)
	);

	frame_checker #(
		.POSITION_LIMIT(POS_LIMIT)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.rx_valid(rx_valid),
		.rx_ready(rx_ready),
		.rx_data(rx_data),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_data(res_data),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	always #4 clk = ~clk;

	// receiver stall pattern, switched whenever the low six bits of ready_tick are zero
	always @(posedge clk) begin
		ready_tick <= ready_tick + 8'd1;
		if (ready_tick[5:0] == 6'd0)
			ready_mode <= 2'($urandom_range(0, 3));
		case (ready_mode)
			2'd0: res_ready <= 1'b1;
			2'd1: res_ready <= 1'($urandom_range(0, 1));
			2'd2: res_ready <= (ready_tick[1:0] == 2'd0);
			default: res_ready <= (ready_tick[3:2] != 2'b11);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((rx_valid && rx_ready) || (res_valid && res_ready) || cfg_we)
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = sender_idles ? $urandom_range(0, 12) : 0;
			if (gap > 0) begin
				rx_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		rx_valid <= 1'b1;
		rx_data <= '{rx_byte: b, frame_last: last};
		do @(posedge clk); while (!rx_ready);
		sent_bytes++;
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_buf.size(); i++)
			send_byte(frame_buf[i], i == frame_buf.size() - 1);
	endtask

	task automatic build_frame(input flaw_t flaw, input logic [7:0] len, input int body);
		logic [7:0] typ;
		logic [7:0] rcp;
		logic [7:0] sum;
		logic [7:0] b;
		int         n;
		frame_buf.delete();
		if (flaw == FLAW_NOISE) begin
			n = $urandom_range(1, 14);
			repeat (n) frame_buf.push_back(8'($urandom));
			return;
		end
		case ($urandom_range(0, 3))
			0: typ = live_cfg.type_command;
			1: typ = live_cfg.type_response;
			2: typ = live_cfg.type_status;
			default: typ = live_cfg.type_error;
		endcase
		if (flaw == FLAW_TYPE) begin
			do typ = 8'($urandom);
			while (typ == live_cfg.type_command || typ == live_cfg.type_response ||
			       typ == live_cfg.type_status || typ == live_cfg.type_error);
		end
		rcp = 8'($urandom);
		sum = rcp ^ typ ^ len;
		if (flaw == FLAW_START)
			frame_buf.push_back(live_cfg.start_byte ^ 8'($urandom_range(1, 255)));
		else
			frame_buf.push_back(live_cfg.start_byte);
		frame_buf.push_back(rcp);
		frame_buf.push_back(typ);
		frame_buf.push_back(len);
		frame_buf.push_back(8'h00);
		n = (flaw == FLAW_SHORT) ? len : body;
		repeat (n) begin
			b = 8'($urandom);
			sum ^= b;
			frame_buf.push_back(b);
		end
		// checksum byte makes the xor over the inner bytes zero
		frame_buf[4] = (flaw == FLAW_CHECKSUM) ? sum ^ 8'($urandom_range(1, 255)) : sum;
		if (flaw == FLAW_END)
			frame_buf.push_back(live_cfg.end_byte ^ 8'($urandom_range(1, 255)));
		else
			frame_buf.push_back(live_cfg.end_byte);
		if (flaw == FLAW_SHORT) begin
			while (frame_buf.size() > body)
				void'(frame_buf.pop_back());
			if ($urandom_range(0, 1))
				frame_buf[body - 1] = live_cfg.end_byte;
		end
	endtask

	task automatic drain();
		rx_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [7:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
	endtask

	task automatic apply_cfg(input cfg_t c);
		drain();
		write_reg(CFG_START_BYTE, c.start_byte);
		write_reg(CFG_END_BYTE, c.end_byte);
		write_reg(CFG_TYPE_COMMAND, c.type_command);
		write_reg(CFG_TYPE_RESPONSE, c.type_response);
		write_reg(CFG_TYPE_STATUS, c.type_status);
		write_reg(CFG_TYPE_ERROR, c.type_error);
		cfg_we <= 1'b0;
		live_cfg = c;
	endtask

	function automatic cfg_t random_cfg();
		cfg_t c;
		c.start_byte = 8'($urandom);
		c.end_byte = 8'($urandom);
		c.type_command = 8'($urandom);
		c.type_response = 8'($urandom);
		c.type_status = 8'($urandom);
		c.type_error = 8'($urandom);
		return c;
	endfunction

	task automatic run_random(input int n_bytes);
		int         target;
		flaw_t      flaw;
		logic [7:0] len;
		int         body;
		target = sent_bytes + n_bytes;
		while (sent_bytes < target) begin
			sender_idles = ($urandom_range(0, 4) != 0);
			flaw = ($urandom_range(0, 9) < 5) ? FLAW_NONE : flaw_t'($urandom_range(1, 7));
			len = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(11, 40))
				: 8'($urandom_range(0, 10));
			if (flaw == FLAW_LENGTH)
				body = (len > 0 && $urandom_range(0, 1)) ? len - 1 : len + $urandom_range(1, 3);
			else if (flaw == FLAW_SHORT)
				body = $urandom_range(1, 5);
			else
				body = len;
			build_frame(flaw, len, body);
			send_frame();
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset register values: frames that end ok, with a checksum or type error, or malformed
		build_frame(FLAW_NONE, 8'd0, 0);
		send_frame();
		build_frame(FLAW_NONE, 8'd1, 1);
		send_frame();
		build_frame(FLAW_CHECKSUM, 8'd0, 0);
		send_frame();
		build_frame(FLAW_TYPE, 8'd0, 0);
		send_frame();
		build_frame(FLAW_SHORT, 8'd0, 1);
		send_frame();
		build_frame(FLAW_SHORT, 8'd0, 3);
		send_frame();
		run_random(PHASE_BYTES);

		apply_cfg('{start_byte: 8'h00, end_byte: 8'hff, type_command: 8'h00,
			type_response: 8'h00, type_status: 8'hff, type_error: 8'h80});
		run_random(PHASE_BYTES);

		apply_cfg('{start_byte: 8'hff, end_byte: 8'h00, type_command: 8'hff,
			type_response: 8'hfe, type_status: 8'h01, type_error: 8'h7f});
		run_random(PHASE_BYTES);

		apply_cfg(random_cfg());
		run_random(PHASE_BYTES);

		// frame that saturates the byte counter and the payload index
		apply_cfg(random_cfg());
		sender_idles = 1'b1;
		build_frame(FLAW_NONE, 8'($urandom), 264);
		send_frame();
		run_random(40);

		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
